// ===== rtl/rqr_pkg.sv =====
package rqr_pkg;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int PROC_ID_W = 8;
  localparam int COUNT_W   = 5;

  typedef struct packed {
    logic [1:0]           operation;
    logic [PROC_ID_W-1:0] proc_id;
  } cmd_beat_t;

  typedef struct packed {
    logic [PROC_ID_W-1:0] out_id;
    logic [1:0]           status;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;
  } res_beat_t;

  typedef struct packed {
    logic commit;
    logic enq;
    logic deq;
    logic rmv;
  } cell_ctl_t;

endpackage

// ===== rtl/ready_queue_with_remove_by_id.sv =====
// The result beat is registered when a command beat is accepted and is valid in the cycle after it.
// Throughput: one command per cycle while results are taken; the output
// register holds a result and stalls new commands only while it waits.
// The match search ripples through the cell chain combinationally in the accept cycle.
// Reset empties the queue and clears the output valid; stored ids stay.
module ready_queue_with_remove_by_id #(
  parameter int CAPACITY = 16,
  parameter int ID_WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  rqr_pkg::cmd_beat_t cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output rqr_pkg::res_beat_t res
);
  import rqr_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int EXTW = (ID_WIDTH > PROC_ID_W) ? ID_WIDTH : PROC_ID_W;
  localparam int EW   = (CW > COUNT_W) ? CW : COUNT_W;

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                accept;
  cell_ctl_t           ctl;
  logic [EXTW-1:0]     key_ext;
  logic [ID_WIDTH-1:0] key;
  logic [CAPACITY-1:0] vld;
  logic [ID_WIDTH-1:0] ids  [CAPACITY];
  logic [CAPACITY:0]   hit;
  logic [ID_WIDTH-1:0] take [CAPACITY+1];
  logic [1:0]          status_next;
  logic [EXTW-1:0]     got_ext;
  logic [EW-1:0]       cnt_ext;

  assign cmd_ready = ~res_valid | res_ready;
  assign accept    = cmd_valid & cmd_ready;
  assign key_ext   = EXTW'(cmd.proc_id);
  assign key       = key_ext[ID_WIDTH-1:0];

  assign ctl.commit = accept;
  assign ctl.enq    = (cmd.operation == OP_ENQUEUE);
  assign ctl.deq    = (cmd.operation == OP_DEQUEUE);
  assign ctl.rmv    = (cmd.operation == OP_REMOVE);

  assign hit[0]  = 1'b0;
  assign take[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rqr_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .key       (key),
      .head_take ((i == 0) ? ctl.deq : 1'b0),
      .prev_valid((i == 0) ? 1'b1 : vld[(i == 0) ? 0 : i - 1]),
      .hit_in    (hit[i]),
      .take_in   (take[i]),
      .next_valid((i == CAPACITY - 1) ? 1'b0 : vld[(i == CAPACITY - 1) ? i : i + 1]),
      .next_id   ((i == CAPACITY - 1) ? '0 : ids[(i == CAPACITY - 1) ? i : i + 1]),
      .valid     (vld[i]),
      .id        (ids[i]),
      .hit_out   (hit[i+1]),
      .take_out  (take[i+1])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    unique case (cmd.operation)
      OP_ENQUEUE: begin
        if (count == CW'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_DEQUEUE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      OP_REMOVE: begin
        if (hit[CAPACITY]) begin
          count_next = count - CW'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign got_ext = EXTW'(take[CAPACITY]);
  assign cnt_ext = EW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.out_id      <= got_ext[PROC_ID_W-1:0];
      res.status      <= status_next;
      res.entry_count <= cnt_ext[COUNT_W-1:0];
      res.is_empty    <= (count_next == '0);
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == int'(count))
    else $error("entry count differs from occupied cells");

  a_valid_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((vld + CAPACITY'(1)) & vld) == '0)
    else $error("occupied cells are not packed toward the head");

  a_dequeue_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.deq && count != '0) |=> count == $past(count) - CW'(1))
    else $error("dequeue did not shrink the queue");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_EMPTY) |-> (res.is_empty && res.out_id == '0))
    else $error("empty status without empty queue");

endmodule

// ===== rtl/rqr_cell.sv =====
module rqr_cell #(
  parameter int ID_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  rqr_pkg::cell_ctl_t  ctl,
  input  logic [ID_WIDTH-1:0] key,
  input  logic                head_take,
  input  logic                prev_valid,
  input  logic                hit_in,
  input  logic [ID_WIDTH-1:0] take_in,
  input  logic                next_valid,
  input  logic [ID_WIDTH-1:0] next_id,
  output logic                valid,
  output logic [ID_WIDTH-1:0] id,
  output logic                hit_out,
  output logic [ID_WIDTH-1:0] take_out
);
  import rqr_pkg::*;

  logic match;
  logic shift;
  logic write;

  assign match    = valid & (head_take | (ctl.rmv & (id == key)));
  assign hit_out  = hit_in | match;
  assign take_out = hit_in ? take_in : (match ? id : '0);
  assign shift    = ctl.commit & hit_out;
  assign write    = ctl.commit & ctl.enq & ~valid & prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= next_valid;
    end else if (write) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      id <= next_id;
    end else if (write) begin
      id <= key;
    end
  end

endmodule
